@@ src/mdr_pkg.sv @@
`timescale 1ns / 1ps
package mdr_pkg;

    localparam int W = 64;
    localparam int H = W / 2;
    localparam int DIV_STEPS = 2 * W;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OVF     = 2'd1,
        ST_DIV0    = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    // Sideband that travels with every item through the pipeline.
    typedef struct packed {
        logic    func;
        status_t status;
    } side_t;

    // One division stage: numerator and quotient share num.
    typedef struct packed {
        side_t            side;
        logic [2*W-1:0]   num;
        logic [W-1:0]     rem;
        logic [W-1:0]     d;
    } div_t;

endpackage

@@ src/mdr_mul.sv @@
`timescale 1ns / 1ps
module mdr_mul
    import mdr_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           ce,
    input  logic           in_valid,
    input  side_t          in_side,
    input  logic           in_up,
    input  logic [W-1:0]   in_a,
    input  logic [W-1:0]   in_b,
    input  logic [W-1:0]   in_c,
    output logic           out_valid,
    output div_t           out_div
);

    logic           v1_reg, v2_reg, v3_reg;
    side_t          s1_reg, s2_reg;
    logic           up1_reg, up2_reg;
    logic [W-1:0]   c1_reg, c2_reg;
    logic [W-1:0]   ll_reg, lh_reg, hl_reg, hh_reg;
    logic [2*W-1:0] prod_reg;
    div_t           div_reg;
    div_t           div_next;
    logic [2*W-1:0] prod_next;

    always_comb
    begin
        prod_next = {{W{1'b0}}, ll_reg}
                  + {{H{1'b0}}, lh_reg, {H{1'b0}}}
                  + {{H{1'b0}}, hl_reg, {H{1'b0}}}
                  + {hh_reg, {W{1'b0}}};
    end

    // Rounding up adds divisor - 1; the sum cannot pass 2^128.
    always_comb
    begin
        div_next.side = s2_reg;
        div_next.num  = up2_reg ? prod_reg + {{W{1'b0}}, c2_reg - 1'b1} : prod_reg;
        div_next.rem  = '0;
        div_next.d    = c2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_reg  <= in_side;
            up1_reg <= in_up;
            c1_reg  <= in_c;
            ll_reg  <= in_a[H-1:0] * in_b[H-1:0];
            lh_reg  <= in_a[H-1:0] * in_b[W-1:H];
            hl_reg  <= in_a[W-1:H] * in_b[H-1:0];
            hh_reg  <= in_a[W-1:H] * in_b[W-1:H];
            s2_reg   <= s1_reg;
            up2_reg  <= up1_reg;
            c2_reg   <= c1_reg;
            prod_reg <= prod_next;
            div_reg  <= div_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_div   = div_reg;

endmodule

@@ src/mdr_div_step.sv @@
`timescale 1ns / 1ps
module mdr_div_step
    import mdr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic ce,
    input  logic in_valid,
    input  div_t in_div,
    output logic out_valid,
    output div_t out_div
);

    logic         valid_reg;
    div_t         div_reg;
    div_t         div_next;
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         take;

    // One restoring step: shift the next numerator bit into the remainder.
    always_comb
    begin
        trial = {in_div.rem, in_div.num[2*W-1]};
        diff  = trial - {1'b0, in_div.d};
        take  = trial >= {1'b0, in_div.d};
        div_next      = in_div;
        div_next.rem  = take ? diff[W-1:0] : trial[W-1:0];
        div_next.num  = {in_div.num[2*W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;

endmodule

@@ src/mul_div_64_rounded.sv @@
`timescale 1ns / 1ps
// Pipeline: 3 multiply and rounding stages, 128 restoring division stages
// and 1 output stage between an input transfer and its result.
// Throughput: one transfer per cycle; the whole pipeline holds while the
// output is stalled. rst_n clears all valid bits asynchronously.
module mul_div_64_rounded
    import mdr_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [191:0]   s_tdata,  // mul_a, mul_b, divisor
    input  logic [1:0]     s_tuser,  // func, round_up
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [63:0]    m_tdata,  // quotient
    output logic [1:0]     m_tuser   // status
);

    logic         ce;
    side_t        in_side;
    logic [W-1:0] a, b, c;
    logic         v_pipe [0:DIV_STEPS];
    div_t         d_pipe [0:DIV_STEPS];
    div_t         last;
    logic         out_valid_reg;
    logic [W-1:0] quot_reg, quot_next;
    status_t      stat_reg, stat_next;

    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;

    assign a = s_tdata[W-1:0];
    assign b = s_tdata[2*W-1:W];
    assign c = s_tdata[3*W-1:2*W];

    always_comb
    begin
        in_side.func = s_tuser[0];
        if (s_tuser[0] && (a[W-1] || b[W-1] || c[W-1]))
        begin
            in_side.status = ST_INVALID;
        end
        else if (c == '0)
        begin
            in_side.status = ST_DIV0;
        end
        else
        begin
            in_side.status = ST_OK;
        end
    end

    mdr_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .in_side   (in_side),
        .in_up     (s_tuser[1]),
        .in_a      (a),
        .in_b      (b),
        .in_c      (c),
        .out_valid (v_pipe[0]),
        .out_div   (d_pipe[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        mdr_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .ce        (ce),
            .in_valid  (v_pipe[i]),
            .in_div    (d_pipe[i]),
            .out_valid (v_pipe[i+1]),
            .out_div   (d_pipe[i+1])
        );
    end

    assign last = d_pipe[DIV_STEPS];

    always_comb
    begin
        quot_next = last.num[W-1:0];
        stat_next = last.side.status;
        if (last.side.status != ST_OK)
        begin
            quot_next = '0;
        end
        else if (last.num[2*W-1:W] != '0 || (last.side.func && last.num[W-1]))
        begin
            stat_next = ST_OVF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= v_pipe[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            quot_reg <= quot_next;
            stat_reg <= stat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = quot_reg;
    assign m_tuser  = stat_reg;

`ifndef SYNTH
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_DIV0 || m_tuser == ST_INVALID) |-> m_tdata == '0)
        else $error("error result carries a nonzero quotient");
    a_signed_limit: assert property (@(posedge clk) disable iff (!rst_n)
        v_pipe[DIV_STEPS] && ce && last.side.func && last.side.status == ST_OK
        && last.num[W-1] |=> m_tuser == ST_OVF)
        else $error("signed quotient above 63 bits not flagged");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(v_pipe[DIV_STEPS]) && $stable(m_tdata))
        else $error("pipeline moved during an output stall");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import mdr_pkg::*;

    typedef struct {
        logic [63:0] quotient;
        status_t     status;
    } muldiv_res_t;

    logic           clk;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [191:0]   s_tdata;   // mul_a, mul_b, divisor
    logic [1:0]     s_tuser;   // func, round_up
    logic           m_tvalid;
    logic           m_tready;
    logic [63:0]    m_tdata;   // quotient
    logic [1:0]     m_tuser;   // status

    muldiv_res_t quot_queue[$];
    int          errors;
    int unsigned cycle_count;
    bit          sink_idle_en;
    bit          src_idle_en;
    bit          long_hold;

    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int unsigned CYCLE_LIMIT = 400000;

    mul_div_64_rounded dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Exact a*b/c with optional ceiling rounding, computed in 129-bit arithmetic.
    function automatic muldiv_res_t predict_quotient(logic func, logic [63:0] a,
                                                     logic [63:0] b, logic [63:0] c,
                                                     logic up);
        muldiv_res_t r;
        logic [128:0] num;
        logic [128:0] q;
        r.quotient = '0;
        if (func && ((a | b | c) & 64'h8000_0000_0000_0000) != 0)
        begin
            r.status = ST_INVALID;
            return r;
        end
        if (c == 0)
        begin
            r.status = ST_DIV0;
            return r;
        end
        num = {1'b0, a} * {1'b0, b};
        if (up)
            num = num + c - 1;
        q = num / c;
        r.quotient = q[63:0];
        if (q[128:64] != 0 || (func && q[63:0] > MAX63))
            r.status = ST_OVF;
        else
            r.status = ST_OK;
        return r;
    endfunction

    task automatic send_op(logic func, logic [63:0] a, logic [63:0] b,
                           logic [63:0] c, logic up);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c, b, a};
        s_tuser  <= {up, func};
        quot_queue.insert(quot_queue.size(), predict_quotient(func, a, b, c, up));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic finish_sends();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(0, 63);
            1: v = MAX64 >> $urandom_range(0, 63);
            2: v = 64'd1 << $urandom_range(0, 63);
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        logic [63:0] ext [6];
        ext = '{64'd0, 64'd1, MAX63, 64'h8000_0000_0000_0000, MAX64, 64'd3};
        send_op(1'b0, MAX64, MAX64, MAX64, 1'b0);
        send_op(1'b0, MAX64, MAX64, MAX64, 1'b1);
        send_op(1'b0, MAX64, MAX64, 64'd1, 1'b0);
        send_op(1'b0, MAX64, MAX64, 64'd1, 1'b1);
        send_op(1'b0, 64'd0, 64'd0, 64'd1, 1'b1);
        send_op(1'b0, 64'd7, 64'd3, 64'd0, 1'b0);
        send_op(1'b1, 64'd7, 64'd3, 64'd0, 1'b1);
        send_op(1'b1, 64'h8000_0000_0000_0000, 64'd1, 64'd0, 1'b0);
        send_op(1'b1, 64'd1, 64'h8000_0000_0000_0000, 64'd1, 1'b0);
        send_op(1'b1, 64'd1, 64'd1, 64'h8000_0000_0000_0000, 1'b0);
        send_op(1'b1, MAX63, MAX63, MAX63, 1'b1);
        send_op(1'b1, MAX63, 64'd2, 64'd2, 1'b0);
        send_op(1'b1, MAX63, 64'd2, 64'd1, 1'b0);
        send_op(1'b1, 64'h4000_0000_0000_0000, 64'd2, 64'd1, 1'b0);
        send_op(1'b0, 64'd7, 64'd3, 64'd2, 1'b0);
        send_op(1'b0, 64'd7, 64'd3, 64'd2, 1'b1);
        send_op(1'b0, 64'd6, 64'd3, 64'd2, 1'b1);
        for (int i = 0; i < 6; i++)
            send_op(i[0], ext[i], ext[5 - i], ext[(i + 2) % 6], i[1]);
        finish_sends();
    endtask

    // Hold the output off long enough that the pipeline fills and stalls the input.
    task automatic test_backpressure();
        long_hold = 1'b1;
        for (int i = 0; i < 250; i++)
            send_op(1'($urandom_range(0, 1)), rand64(), rand64(), rand64(),
                    1'($urandom_range(0, 1)));
        finish_sends();
    endtask

    task automatic test_random();
        logic [63:0] a, b, c;
        logic        func;
        for (int i = 0; i < 480; i++)
        begin
            func = 1'($urandom_range(0, 1));
            a = rand64();
            b = rand64();
            c = rand64();
            // Mostly valid signed operands so the divider path is exercised.
            if (func && $urandom_range(0, 7) != 0)
            begin
                a[63] = 1'b0;
                b[63] = 1'b0;
                c[63] = 1'b0;
            end
            // Divisors near the high product keep quotients in range sometimes.
            if ($urandom_range(0, 3) == 0 && a != 0)
                c = a >> $urandom_range(0, 2);
            if ($urandom_range(0, 30) == 0)
                c = 64'd0;
            if (i == 380)
            begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            send_op(func, a, b, c, 1'($urandom_range(0, 1)));
        end
        finish_sends();
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int n;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 5);
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        muldiv_res_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (quot_queue.size() == 0)
            begin
                $error("unexpected result: quotient %h status %0d", m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                exp_res = quot_queue.pop_front();
                if (m_tdata !== exp_res.quotient)
                begin
                    $error("quotient: expected %h actual %h", exp_res.quotient, m_tdata);
                    errors++;
                end
                if (m_tuser !== exp_res.status)
                begin
                    $error("status: expected %0d actual %0d", exp_res.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        errors       = 0;
        cycle_count  = 0;
        sink_idle_en = 1'b1;
        src_idle_en  = 1'b1;
        long_hold    = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        while (quot_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
